// ----- rtl/rigid_body_euler_ground_bounce_macros.svh -----
// Assertion macros used by the rbg_checker file.
`ifndef RIGID_BODY_EULER_GROUND_BOUNCE_MACROS_SVH
`define RIGID_BODY_EULER_GROUND_BOUNCE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RBG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RBG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/rbg_pkg.sv -----
// ---------------------------------------------------------------------------
// rbg_pkg
// Shared types, op codes and helpers for the rigid body bounce block.
// ---------------------------------------------------------------------------
package rbg_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SETPOS = 3'd1,
    OP_SETROT = 3'd2,
    OP_SETVEL = 3'd3,
    OP_SETSPN = 3'd4,
    OP_SETKCK = 3'd5,
    OP_SETSKK = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  localparam logic [2:0] CFG_GRAVITY = 3'd0;
  localparam logic [2:0] CFG_REST    = 3'd1;
  localparam logic [2:0] CFG_RADIUS  = 3'd2;
  localparam logic [2:0] CFG_STOP    = 3'd3;
  localparam logic [2:0] CFG_CLIMIT  = 3'd4;
  localparam logic [2:0] CFG_SPINX   = 3'd5;
  localparam logic [2:0] CFG_SPINY   = 3'd6;
  localparam logic [2:0] CFG_SPINZ   = 3'd7;

  // Lane phase selects the multiplier operands.
  typedef enum logic [1:0] {
    LN_INTEG = 2'd0,
    LN_ACCEL = 2'd1,
    LN_BOUNCE = 2'd2
  } lane_ph_t;

  // Saturate a 51-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [50:0] mx;
    logic signed [50:0] mn;
    begin
      mx = 51'sd2147483647;
      mn = -51'sd2147483648;
      if (v > mx) sat32 = 32'sh7fffffff;
      else if (v < mn) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage

// ----- rtl/rigid_body_euler_ground_bounce.sv -----
// ---------------------------------------------------------------------------
// rigid_body_euler_ground_bounce
// One rigid body stepped by explicit Euler with a ground bounce.
// ---------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one word: op, dt and a vector.
// A tick integrates the body; the other ops load one state vector.
// Result channel out_valid/out_ready returns the state after each word
// with the bounced and stopped flags.
// Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data
// and are always taken.
// Six lanes (three linear, three angular) share each phase of a tick.
// A tick raises out_valid once it has stepped through integrate,
// accelerate, contact test and bounce scale, each multiply registered in the
// lanes. A load op goes straight to S_OUT, which then raises out_valid.
// One word is in flight at a time, so the next word is not accepted
// until the block is idle again and the last result is being taken.
// The result sits in an output register; a stalled receiver holds it and
// the next word is accepted in the same cycle the result is taken.
// Reset clears all state to zero and the registers to their defaults.
// ---------------------------------------------------------------------------
module rigid_body_euler_ground_bounce (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic [15:0]        in_dt,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_rot_x,
  output logic signed [31:0] out_rot_y,
  output logic signed [31:0] out_rot_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic               out_bounced,
  output logic               out_stopped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import rbg_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_INT   = 8'b00000010,
    S_INTW  = 8'b00000100,
    S_ACC   = 8'b00001000,
    S_ACCW  = 8'b00010000,
    S_TEST  = 8'b00100000,
    S_BNCW  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic [30:0] gravity_r;
  logic [16:0] rest_r;
  logic [30:0] radius_r;
  logic [30:0] stop_r;
  logic [30:0] climit_r;
  logic signed [31:0] sacc_r [3];

  logic signed [31:0] pos_r [3];
  logic signed [31:0] rot_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] spn_r [3];
  logic signed [31:0] kck_r [3];
  logic signed [31:0] skk_r [3];
  logic [31:0]        ct_r;
  logic [15:0]        dt_r;
  logic               bnc_r, stp_r;
  logic               out_valid_r;

  // Lane operands.
  logic signed [33:0] la [6];
  logic        [16:0] lb;
  logic signed [31:0] lbase [6];
  logic               luse;
  logic signed [31:0] lres [6];

  lane_ph_t ph;

  genvar g;
  generate
    for (g = 0; g < 6; g++) begin : g_lane
      rbg_lane u_lane (
        .clk(clk), .a(la[g]), .b(lb), .base(lbase[g]), .use_base(luse),
        .res(lres[g])
      );
    end
  endgenerate

  // Operand selection per phase.
  always_comb begin
    ph = LN_INTEG;
    if (state_r == S_ACC) ph = LN_ACCEL;
    else if (state_r == S_TEST) ph = LN_BOUNCE;
    lb   = {1'b0, dt_r};
    luse = 1'b1;
    for (int i = 0; i < 3; i++) begin
      la[i]      = 34'(vel_r[i]);
      la[i+3]    = 34'(spn_r[i]);
      lbase[i]   = pos_r[i];
      lbase[i+3] = rot_r[i];
    end
    case (ph)
      LN_ACCEL: begin
        for (int i = 0; i < 3; i++) begin
          la[i]      = 34'(kck_r[i]);
          la[i+3]    = 34'(sacc_r[i]) + 34'(skk_r[i]);
          lbase[i]   = vel_r[i];
          lbase[i+3] = spn_r[i];
        end
        la[1] = 34'(kck_r[1]) - 34'($signed({1'b0, gravity_r}));
      end
      LN_BOUNCE: begin
        lb   = rest_r;
        luse = 1'b0;
        for (int i = 0; i < 3; i++) begin
          la[i]   = 34'(vel_r[i]);
          la[i+3] = 34'(spn_r[i]);
        end
        la[1] = -34'(vel_r[1]);
      end
      default: ;
    endcase
  end

  // Contact test on the updated state; squares over the merged lanes.
  logic        hit;
  logic [63:0] sq [3];
  logic [65:0] sp2;
  logic [61:0] lim2;
  logic        kicked;
  logic [32:0] ct_sum;
  logic [31:0] mag [3];
  logic [63:0] sq_r [3];
  logic [61:0] lim2_r;

  always_comb begin
    hit = (33'(pos_r[1]) - 33'($signed({2'b0, radius_r})) < 0) && vel_r[1][31];
    for (int i = 0; i < 3; i++) begin
      mag[i] = vel_r[i][31] ? 32'(-33'(vel_r[i])) : vel_r[i];
      sq[i]  = 64'(mag[i]) * 64'(mag[i]);
    end
    lim2 = 62'(stop_r) * 62'(stop_r);
    sp2  = 66'(sq_r[0]) + 66'(sq_r[1]) + 66'(sq_r[2]);
    kicked = (kck_r[0] != 0) || (kck_r[1] != 0) || (kck_r[2] != 0);
    ct_sum = 33'(ct_r) + 33'(dt_r);
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) state_nxt = (op_t'(in_op) == OP_TICK) ? S_INT : S_OUT;
      S_INT:  state_nxt = S_INTW;
      S_INTW: state_nxt = S_ACC;
      S_ACC:  state_nxt = S_ACCW;
      S_ACCW: state_nxt = S_TEST;
      S_TEST: state_nxt = S_BNCW;
      S_BNCW: state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gravity_r <= 31'd642908;
      rest_r    <= 17'd52429;
      radius_r  <= 31'd65536;
      stop_r    <= 31'd65536;
      climit_r  <= 31'd3277;
      ct_r      <= '0;
      bnc_r     <= 1'b0;
      stp_r     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sacc_r[i] <= '0; pos_r[i] <= '0; rot_r[i] <= '0; vel_r[i] <= '0;
        spn_r[i] <= '0; kck_r[i] <= '0; skk_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      // Register writes.
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_GRAVITY: gravity_r <= cfg_data[30:0];
          CFG_REST:    rest_r    <= cfg_data[16:0];
          CFG_RADIUS:  radius_r  <= cfg_data[30:0];
          CFG_STOP:    stop_r    <= cfg_data[30:0];
          CFG_CLIMIT:  climit_r  <= cfg_data[30:0];
          CFG_SPINX:   sacc_r[0] <= cfg_data;
          CFG_SPINY:   sacc_r[1] <= cfg_data;
          CFG_SPINZ:   sacc_r[2] <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          dt_r  <= in_dt;
          bnc_r <= 1'b0;
          stp_r <= 1'b0;
          case (op_t'(in_op))
            OP_SETPOS: begin pos_r[0] <= in_vec_x; pos_r[1] <= in_vec_y; pos_r[2] <= in_vec_z; end
            OP_SETROT: begin rot_r[0] <= in_vec_x; rot_r[1] <= in_vec_y; rot_r[2] <= in_vec_z; end
            OP_SETVEL: begin vel_r[0] <= in_vec_x; vel_r[1] <= in_vec_y; vel_r[2] <= in_vec_z; end
            OP_SETSPN: begin spn_r[0] <= in_vec_x; spn_r[1] <= in_vec_y; spn_r[2] <= in_vec_z; end
            OP_SETKCK: begin kck_r[0] <= in_vec_x; kck_r[1] <= in_vec_y; kck_r[2] <= in_vec_z; end
            OP_SETSKK: begin skk_r[0] <= in_vec_x; skk_r[1] <= in_vec_y; skk_r[2] <= in_vec_z; end
            default: ;
          endcase
        end
        S_INTW: for (int i = 0; i < 3; i++) begin
          pos_r[i] <= lres[i];
          rot_r[i] <= lres[i+3];
        end
        S_ACCW: begin
          for (int i = 0; i < 3; i++) begin
            vel_r[i] <= lres[i];
            spn_r[i] <= lres[i+3];
          end
          // Kick clear and contact timer.
          if (kicked && ct_r > {1'b0, climit_r}) begin
            for (int i = 0; i < 3; i++) begin
              kck_r[i] <= '0;
              skk_r[i] <= '0;
            end
            ct_r <= {16'd0, dt_r};
          end else begin
            ct_r <= ct_sum[32] ? 32'hffffffff : ct_sum[31:0];
          end
        end
        S_TEST: begin
          for (int i = 0; i < 3; i++) sq_r[i] <= sq[i];
          lim2_r <= lim2;
        end
        S_BNCW: if (hit) begin
          if (sp2 > 66'(lim2_r)) begin
            bnc_r <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              vel_r[i] <= lres[i];
              spn_r[i] <= lres[i+3];
            end
          end else begin
            stp_r <= 1'b1;
            pos_r[1] <= $signed({1'b0, radius_r});
            for (int i = 0; i < 3; i++) begin
              vel_r[i] <= '0;
              spn_r[i] <= '0;
            end
          end
        end
        S_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pos_x   = pos_r[0];
  assign out_pos_y   = pos_r[1];
  assign out_pos_z   = pos_r[2];
  assign out_rot_x   = rot_r[0];
  assign out_rot_y   = rot_r[1];
  assign out_rot_z   = rot_r[2];
  assign out_vel_x   = vel_r[0];
  assign out_vel_y   = vel_r[1];
  assign out_vel_z   = vel_r[2];
  assign out_bounced = bnc_r;
  assign out_stopped = stp_r;
endmodule

// ----- rtl/rbg_lane.sv -----
// ---------------------------------------------------------------------------
// rbg_lane
// One vector component: a registered signed multiply by a 17-bit factor,
// floor shift by 16, an optional add to a base value, and saturation.
// ---------------------------------------------------------------------------
module rbg_lane (
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic        [16:0] b,
  input  logic signed [31:0] base,
  input  logic               use_base,
  output logic signed [31:0] res
);
  import rbg_pkg::*;

  logic signed [51:0] prod_r;
  logic signed [31:0] base_r;
  logic               use_base_r;
  logic signed [50:0] sum;

  // Product is registered before the add.
  always_ff @(posedge clk) begin
    prod_r     <= a * $signed({1'b0, b});
    base_r     <= base;
    use_base_r <= use_base;
  end

  // Arithmetic shift gives the floor of the quotient.
  always_comb begin
    sum = 51'(prod_r >>> 16);
    if (use_base_r) sum = sum + 51'(base_r);
    res = sat32(sum);
  end
endmodule

// ----- rtl/rbg_checker.sv -----
// ---------------------------------------------------------------------------
// rbg_checker
// Port-level checks on the rigid body bounce block.
// ---------------------------------------------------------------------------
`include "rigid_body_euler_ground_bounce_macros.svh"
module rbg_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_bounced,
  input logic out_stopped
);
  // A result is never both a bounce and a stop.
  `RBG_ASSERT_IMP(a_flags_excl, out_valid, !(out_bounced && out_stopped))
  // One word in flight: no accept while a result is pending and stalled.
  `RBG_ASSERT_IMP(a_no_accept_stall, out_valid && !out_ready, !in_ready)
  // After an accept, the block is busy the next cycle.
  `RBG_ASSERT_NXT(a_busy_after, in_valid && in_ready, !in_ready)
  // Result held while stalled.
  `RBG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

bind rigid_body_euler_ground_bounce rbg_checker u_rbg_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_bounced(out_bounced), .out_stopped(out_stopped)
);
